[design/cst_pkg.sv]
package cst_pkg;

  localparam int SLOTS_DEF       = 32768;
  localparam int QUEUE_DEPTH_DEF = 32768;

  localparam logic [15:0] MAX_OPEN_RST = 16'd30000;
  localparam logic [31:0] SOCK_INVALID = 32'hFFFF_FFFF;
  localparam logic [15:0] NO_SLOT      = 16'hFFFF;
  localparam logic [63:0] EMPTY_WORD   = {SOCK_INVALID, 32'h0000_0000};

  // width used to compare a hint against the high-water mark
  localparam int CMP_W = 17;

  // transaction kinds
  localparam logic [2:0] KIND_ADD        = 3'd0;
  localparam logic [2:0] KIND_MODIFY     = 3'd1;
  localparam logic [2:0] KIND_LOOKUP     = 3'd2;
  localparam logic [2:0] KIND_REMOVE     = 3'd3;
  localparam logic [2:0] KIND_REMOVE_ALL = 3'd4;

  // datapath micro operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR_STEP,
    OP_LOAD,
    OP_IDX_ZERO,
    OP_HINT_RD,
    OP_HINT_CHK,
    OP_SCAN_RD,
    OP_SCAN_CHK_SOCK,
    OP_SCAN_CHK_EMPTY,
    OP_POP_RD,
    OP_POP_SLOT_RD,
    OP_POP_CHK,
    OP_EXTEND,
    OP_WIPE_STEP,
    OP_COMMIT
  } cst_op_t;

  typedef struct packed {
    cst_op_t op;
  } cst_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       clr_last;
    logic       can_add;
    logic       hw_zero;
    logic       q_empty;
    logic       sock_invalid;
    logic       idx_lt_hw;
    logic       hint_hit;
    logic       sock_hit;
    logic       empty_hit;
    logic       pop_hit;
    logic       out_free;
  } cst_sts_t;

endpackage

[design/connection_slot_table_core.sv]
// sequence: unknown kind, refused add and lookup of socket -1 go straight to the result;
//   add extends an empty table, else pops the free queue until a pop hits, then scans for
//   an empty slot and extends if none; lookup scans; modify and remove check the hint, then scan;
//   remove all wipes up to the high-water mark; a result still waiting at the output delays the commit
// throughput: one transaction at a time, the next accepted the cycle after the result commits
// reset: synchronous active-low; then a clearing pass over all slots with input stalled
module connection_slot_table_core
  import cst_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic signed [15:0] in_slot_hint,
  input  logic signed [31:0] in_socket_id,
  input  logic [31:0]        in_handle,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_slot_index,
  output logic               out_ok,
  output logic [15:0]        out_table_length,
  // max_open register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_max_open
);

  cst_cmd_t cmd;
  cst_sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // controller sequences hint check, queue pops, scans and commit
  cst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath holds slot memory, free queue, counters and output register
  cst_dp #(
    .SLOTS       (SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_kind          (in_kind),
    .in_slot_hint     (in_slot_hint),
    .in_socket_id     (in_socket_id),
    .in_handle        (in_handle),
    .cfg_valid        (cfg_valid),
    .cfg_max_open     (cfg_max_open),
    .cmd              (cmd),
    .sts              (sts),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_slot_index   (out_slot_index),
    .out_ok           (out_ok),
    .out_table_length (out_table_length)
  );

  // an accepted transaction blocks the input until it commits
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // a failed transaction never reports a slot
  a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_slot_index == NO_SLOT))
    else $error("failed result carries a slot");

  // commit only when the output register can take the result
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_COMMIT) |-> sts.out_free)
    else $error("commit while output register busy");

endmodule

[design/cst_ctrl.sv]
module cst_ctrl
  import cst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  cst_sts_t sts,
  output cst_cmd_t cmd
);

  typedef enum logic [14:0] {
    S_CLEAR    = 15'b000000000000001,
    S_IDLE     = 15'b000000000000010,
    S_DISPATCH = 15'b000000000000100,
    S_HINT_RD  = 15'b000000000001000,
    S_HINT_CHK = 15'b000000000010000,
    S_SCS_RD   = 15'b000000000100000,
    S_SCS_CHK  = 15'b000000001000000,
    S_POP_RD   = 15'b000000010000000,
    S_POP_SLOT = 15'b000000100000000,
    S_POP_CHK  = 15'b000001000000000,
    S_SCE_RD   = 15'b000010000000000,
    S_SCE_CHK  = 15'b000100000000000,
    S_EXTEND   = 15'b001000000000000,
    S_WIPE     = 15'b010000000000000,
    S_FINISH   = 15'b100000000000000
  } cst_state_t;

  cst_state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLR_STEP;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.op = OP_IDX_ZERO;
        unique case (sts.kind)
          KIND_ADD: begin
            if (!sts.can_add) state_nxt = S_FINISH;
            else if (sts.hw_zero) state_nxt = S_EXTEND;
            else state_nxt = S_POP_RD;
          end
          KIND_MODIFY, KIND_REMOVE: state_nxt = S_HINT_RD;
          KIND_LOOKUP: state_nxt = sts.sock_invalid ? S_FINISH : S_SCS_RD;
          KIND_REMOVE_ALL: state_nxt = S_WIPE;
          default: state_nxt = S_FINISH;
        endcase
      end
      S_HINT_RD: begin
        cmd.op    = OP_HINT_RD;
        state_nxt = S_HINT_CHK;
      end
      S_HINT_CHK: begin
        cmd.op = OP_HINT_CHK;
        if (sts.hint_hit || sts.sock_invalid) state_nxt = S_FINISH;
        else state_nxt = S_SCS_RD;
      end
      S_SCS_RD: begin
        if (!sts.idx_lt_hw) state_nxt = S_FINISH;
        else begin
          cmd.op    = OP_SCAN_RD;
          state_nxt = S_SCS_CHK;
        end
      end
      S_SCS_CHK: begin
        cmd.op    = OP_SCAN_CHK_SOCK;
        state_nxt = sts.sock_hit ? S_FINISH : S_SCS_RD;
      end
      S_POP_RD: begin
        if (sts.q_empty) state_nxt = S_SCE_RD;
        else begin
          cmd.op    = OP_POP_RD;
          state_nxt = S_POP_SLOT;
        end
      end
      S_POP_SLOT: begin
        cmd.op    = OP_POP_SLOT_RD;
        state_nxt = S_POP_CHK;
      end
      S_POP_CHK: begin
        cmd.op    = OP_POP_CHK;
        state_nxt = sts.pop_hit ? S_FINISH : S_POP_RD;
      end
      S_SCE_RD: begin
        if (!sts.idx_lt_hw) state_nxt = S_EXTEND;
        else begin
          cmd.op    = OP_SCAN_RD;
          state_nxt = S_SCE_CHK;
        end
      end
      S_SCE_CHK: begin
        cmd.op    = OP_SCAN_CHK_EMPTY;
        state_nxt = sts.empty_hit ? S_FINISH : S_SCE_RD;
      end
      S_EXTEND: begin
        cmd.op    = OP_EXTEND;
        state_nxt = S_FINISH;
      end
      S_WIPE: begin
        if (!sts.idx_lt_hw) state_nxt = S_FINISH;
        else cmd.op = OP_WIPE_STEP;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.op    = OP_COMMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/cst_dp.sv]
module cst_dp
  import cst_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_kind,
  input  logic signed [15:0] in_slot_hint,
  input  logic signed [31:0] in_socket_id,
  input  logic [31:0]        in_handle,
  input  logic               cfg_valid,
  input  logic [15:0]        cfg_max_open,
  input  cst_cmd_t           cmd,
  output cst_sts_t           sts,
  input  logic               out_stall,
  output logic               out_valid,
  output logic signed [15:0] out_slot_index,
  output logic               out_ok,
  output logic [15:0]        out_table_length
);

  localparam int SIDX_W = $clog2(SLOTS);
  localparam int HW_W   = $clog2(SLOTS + 1);
  localparam int QIDX_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [63:0]       slot_mem [SLOTS];
  logic [SIDX_W-1:0] queue_mem [QUEUE_DEPTH];

  logic [2:0]        kind_r;
  logic [15:0]       hint_r;
  logic [31:0]       sock_r, hnd_r;
  logic [15:0]       max_open_r, open_r;
  logic [HW_W-1:0]   hw_r, idx_r;
  logic [QIDX_W-1:0] q_head_r, q_tail_r;
  logic [QCNT_W-1:0] q_count_r;
  logic [SIDX_W-1:0] slot_r, q_rd_r;
  logic              found_r;
  logic [63:0]       slot_rd_r;
  logic              out_valid_r, out_ok_r;
  logic [15:0]       out_slot_r, out_len_r;

  logic              mem_we;
  logic [SIDX_W-1:0] mem_addr;
  logic [63:0]       mem_wdata;
  logic              q_we;
  logic              hint_ok, sock_hit, empty_hit;

  assign hint_ok   = !hint_r[15] && (CMP_W'(hint_r) < CMP_W'(hw_r));
  assign sock_hit  = (slot_rd_r[63:32] == sock_r);
  assign empty_hit = (slot_rd_r == EMPTY_WORD);

  assign sts.kind         = kind_r;
  assign sts.clr_last     = (idx_r == HW_W'(SLOTS - 1));
  assign sts.sock_invalid = (sock_r == SOCK_INVALID);
  assign sts.can_add      = (sock_r != SOCK_INVALID) && (open_r < max_open_r);
  assign sts.hw_zero      = (hw_r == '0);
  assign sts.q_empty      = (q_count_r == '0);
  assign sts.idx_lt_hw    = (idx_r < hw_r);
  assign sts.hint_hit     = hint_ok && sock_hit;
  assign sts.sock_hit     = sock_hit;
  assign sts.empty_hit    = empty_hit;
  assign sts.pop_hit      = (HW_W'(q_rd_r) < hw_r) && empty_hit;
  assign sts.out_free     = !out_valid_r || !out_stall;

  // slot memory port select
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = idx_r[SIDX_W-1:0];
    mem_wdata = EMPTY_WORD;
    unique case (cmd.op)
      OP_CLR_STEP, OP_WIPE_STEP: mem_we = 1'b1;
      OP_HINT_RD:     mem_addr = SIDX_W'(hint_r);
      OP_POP_SLOT_RD: mem_addr = q_rd_r;
      OP_COMMIT: begin
        mem_addr  = slot_r;
        mem_we    = found_r && (kind_r == KIND_ADD || kind_r == KIND_MODIFY ||
                                kind_r == KIND_REMOVE);
        mem_wdata = (kind_r == KIND_REMOVE) ? EMPTY_WORD : {sock_r, hnd_r};
      end
      default: ;
    endcase
  end

  assign q_we = (cmd.op == OP_COMMIT) && (kind_r == KIND_REMOVE) && found_r &&
                (q_count_r < QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_addr] <= mem_wdata;
    else slot_rd_r <= slot_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (q_we) queue_mem[q_tail_r] <= slot_r;
    if (cmd.op == OP_POP_RD) q_rd_r <= queue_mem[q_head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      hw_r        <= '0;
      open_r      <= '0;
      q_head_r    <= '0;
      q_tail_r    <= '0;
      q_count_r   <= '0;
      max_open_r  <= MAX_OPEN_RST;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) max_open_r <= cfg_max_open;
      if (cmd.op == OP_COMMIT) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (cmd.op)
        OP_CLR_STEP, OP_WIPE_STEP: idx_r <= idx_r + 1'b1;
        OP_LOAD: begin
          kind_r  <= in_kind;
          hint_r  <= in_slot_hint;
          sock_r  <= in_socket_id;
          hnd_r   <= in_handle;
          found_r <= 1'b0;
        end
        OP_IDX_ZERO: idx_r <= '0;
        OP_HINT_CHK: begin
          if (hint_ok && sock_hit) begin
            found_r <= 1'b1;
            slot_r  <= SIDX_W'(hint_r);
          end
        end
        OP_SCAN_CHK_SOCK: begin
          if (sock_hit) begin
            found_r <= 1'b1;
            slot_r  <= idx_r[SIDX_W-1:0];
          end else idx_r <= idx_r + 1'b1;
        end
        OP_SCAN_CHK_EMPTY: begin
          if (empty_hit) begin
            found_r <= 1'b1;
            slot_r  <= idx_r[SIDX_W-1:0];
          end else idx_r <= idx_r + 1'b1;
        end
        OP_POP_RD: begin
          q_head_r  <= (q_head_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : q_head_r + 1'b1;
          q_count_r <= q_count_r - 1'b1;
        end
        OP_POP_CHK: begin
          if ((HW_W'(q_rd_r) < hw_r) && empty_hit) begin
            found_r <= 1'b1;
            slot_r  <= q_rd_r;
          end
        end
        OP_EXTEND: begin
          if (hw_r < HW_W'(SLOTS)) begin
            found_r <= 1'b1;
            slot_r  <= hw_r[SIDX_W-1:0];
            hw_r    <= hw_r + 1'b1;
          end
        end
        OP_COMMIT: begin
          if (found_r && kind_r == KIND_ADD) open_r <= open_r + 1'b1;
          if (found_r && kind_r == KIND_REMOVE && open_r != '0) open_r <= open_r - 1'b1;
          if (kind_r == KIND_REMOVE_ALL) open_r <= '0;
          if (q_we) begin
            q_tail_r  <= (q_tail_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : q_tail_r + 1'b1;
            q_count_r <= q_count_r + 1'b1;
          end
          out_slot_r  <= found_r ? 16'(slot_r) : NO_SLOT;
          out_ok_r    <= found_r || (kind_r == KIND_REMOVE_ALL);
          out_len_r   <= 16'(hw_r);
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_slot_index   = out_slot_r;
  assign out_ok           = out_ok_r;
  assign out_table_length = out_len_r;

endmodule
